@@ rtl/chull_pkg.sv @@
// chull_pkg: sizes, point type, command and status structs of the convex hull block
// used by chull_ctrl, chull_dp and convex_hull_8_points_core; no dependencies
package chull_pkg;

    localparam int POINT_COUNT = 8;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(POINT_COUNT);
    localparam int CNT_W       = $clog2(POINT_COUNT + 1);
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int TURN_W      = PROD_W + 1;
    localparam int MAN_W       = DIFF_W + 1;
    localparam int SIZE_W      = 4;
    localparam int SIZE_MAX    = (1 << SIZE_W) - 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef enum logic [2:0] {
        WR_IN,
        WR_RD,
        WR_PIV,
        WR_OPC,
        WR_T
    } t_wr_sel;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_wr_sel          wr_sel;
        logic             piv_load;
        logic             t_load;
        logic             issue;
        logic             scan;
        logic             push;
        logic             pop;
        logic             stk_clr;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic less;
        logic precedes;
        logic nonneg;
        logic depth_ge2;
        logic emit_last;
        logic out_free;
    } t_sts;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [CNT_W-1:0] d);
        if (32'(d) > SIZE_MAX) begin
            return SIZE_W'(SIZE_MAX);
        end
        return SIZE_W'(d);
    endfunction

endpackage

@@ rtl/chull_ctrl.sv @@
// chull_ctrl: sequencer for load, pivot search, insertion sort, stack scan and emit
// depends on chull_pkg; drives the command struct of chull_dp
module chull_ctrl import chull_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [15:0] {
        S_LOAD     = 16'h0001,
        S_PIV_INIT = 16'h0002,
        S_PIV_SCAN = 16'h0004,
        S_SWAP_A   = 16'h0008,
        S_SWAP_B   = 16'h0010,
        S_SRT_T    = 16'h0020,
        S_SRT_CHK  = 16'h0040,
        S_SRT_W1   = 16'h0080,
        S_SRT_W2   = 16'h0100,
        S_SRT_DEC  = 16'h0200,
        S_SCN_RD   = 16'h0400,
        S_SCN_CHK  = 16'h0800,
        S_SCN_W1   = 16'h1000,
        S_SCN_W2   = 16'h2000,
        S_SCN_DEC  = 16'h4000,
        S_EMIT     = 16'h8000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_best, n_best;
    logic [IDX_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] i_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_best <= n_best;
        r_k    <= n_k;
    end

    assign o_in_stall = (r_state != S_LOAD);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_best  = r_best;
        n_k     = r_k;
        i_inc   = r_i + CNT_W'(1);
        o_cmd         = '0;
        o_cmd.wr_sel  = WR_IN;
        o_cmd.rd_addr = r_i[IDX_W-1:0];
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = r_cnt;
                    if (r_cnt == IDX_W'(POINT_COUNT - 1)) begin
                        n_cnt   = '0;
                        n_state = S_PIV_INIT;
                    end else begin
                        n_cnt = r_cnt + IDX_W'(1);
                    end
                end
            end
            S_PIV_INIT: begin
                o_cmd.rd_addr  = '0;
                o_cmd.piv_load = 1'b1;
                n_best         = '0;
                n_i            = CNT_W'(1);
                n_state        = S_PIV_SCAN;
            end
            S_PIV_SCAN: begin
                if (i_sts.less) begin
                    o_cmd.piv_load = 1'b1;
                    n_best         = r_i[IDX_W-1:0];
                end
                if (r_i == CNT_W'(POINT_COUNT - 1)) begin
                    n_state = S_SWAP_A;
                end else begin
                    n_i = i_inc;
                end
            end
            S_SWAP_A: begin
                o_cmd.rd_addr = '0;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_best;
                o_cmd.wr_sel  = WR_RD;
                n_state       = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = '0;
                o_cmd.wr_sel  = WR_PIV;
                o_cmd.stk_clr = 1'b1;
                n_i           = CNT_W'(2);
                n_state       = S_SRT_T;
            end
            S_SRT_T: begin
                o_cmd.t_load = 1'b1;
                n_j          = r_i[IDX_W-1:0];
                n_state      = S_SRT_CHK;
            end
            S_SRT_CHK: begin
                if (r_j == IDX_W'(1)) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = r_j;
                    o_cmd.wr_sel  = WR_T;
                    if (i_inc == CNT_W'(POINT_COUNT)) begin
                        n_i     = '0;
                        n_state = S_SCN_RD;
                    end else begin
                        n_i     = i_inc;
                        n_state = S_SRT_T;
                    end
                end else begin
                    o_cmd.rd_addr = r_j - IDX_W'(1);
                    o_cmd.issue   = 1'b1;
                    n_state       = S_SRT_W1;
                end
            end
            S_SRT_W1: begin
                n_state = S_SRT_W2;
            end
            S_SRT_W2: begin
                n_state = S_SRT_DEC;
            end
            S_SRT_DEC: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_j;
                if (i_sts.precedes) begin
                    o_cmd.wr_sel = WR_OPC;
                    n_j          = r_j - IDX_W'(1);
                    n_state      = S_SRT_CHK;
                end else begin
                    o_cmd.wr_sel = WR_T;
                    if (i_inc == CNT_W'(POINT_COUNT)) begin
                        n_i     = '0;
                        n_state = S_SCN_RD;
                    end else begin
                        n_i     = i_inc;
                        n_state = S_SRT_T;
                    end
                end
            end
            S_SCN_RD: begin
                o_cmd.t_load = 1'b1;
                n_state      = S_SCN_CHK;
            end
            S_SCN_CHK: begin
                if (i_sts.depth_ge2) begin
                    o_cmd.issue = 1'b1;
                    o_cmd.scan  = 1'b1;
                    n_state     = S_SCN_W1;
                end else begin
                    o_cmd.push = 1'b1;
                    n_i        = i_inc;
                    if (i_inc == CNT_W'(POINT_COUNT)) begin
                        n_k     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCN_RD;
                    end
                end
            end
            S_SCN_W1: begin
                n_state = S_SCN_W2;
            end
            S_SCN_W2: begin
                n_state = S_SCN_DEC;
            end
            S_SCN_DEC: begin
                if (i_sts.nonneg) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_SCN_CHK;
                end else begin
                    o_cmd.push = 1'b1;
                    n_i        = i_inc;
                    if (i_inc == CNT_W'(POINT_COUNT)) begin
                        n_k     = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SCN_RD;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.rd_addr = r_k;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

@@ rtl/chull_dp.sv @@
// chull_dp: point store, pivot, cross-product unit, hull stack and output register
// depends on chull_pkg; controlled by chull_ctrl through t_cmd and t_sts
module chull_dp import chull_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_coord                i_point_x,
    input  t_coord                i_point_y,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_coord                o_hull_x,
    output t_coord                o_hull_y,
    output logic [SIZE_W-1:0]     o_hull_size,
    output logic                  o_last_vertex
);

    t_point r_pt [POINT_COUNT];
    t_point r_stk [POINT_COUNT];
    t_point r_piv;
    t_point r_t;
    t_point r_top1;
    t_point r_top2;
    t_point r_oa, r_ob, r_oc;
    logic [CNT_W-1:0] r_depth;

    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic [MAN_W-1:0]         r_mb, r_mc;
    logic                     r_neg, r_zero, r_near;

    logic                     r_out_valid;
    t_coord                   r_hx, r_hy;
    logic [SIZE_W-1:0]        r_hs;
    logic                     r_last;

    t_point                   rd_pt;
    t_point                   wr_data;
    t_point                   stk_rd;
    logic [IDX_W-1:0]         stk_addr;
    logic [CNT_W-1:0]         depth_m3;

    logic signed [DIFF_W-1:0] dbx, dby, dcx, dcy;
    logic [DIFF_W-1:0]        abx, aby, acx, acy;
    logic signed [PROD_W-1:0] n_p1, n_p2;
    logic signed [TURN_W-1:0] n_turn;

    assign rd_pt    = r_pt[i_cmd.rd_addr];
    assign depth_m3 = r_depth - CNT_W'(3);
    assign stk_addr = i_cmd.out_load ? i_cmd.rd_addr : depth_m3[IDX_W-1:0];
    assign stk_rd   = r_stk[stk_addr];

    always_comb begin
        case (i_cmd.wr_sel)
            WR_IN:   wr_data = '{x: i_point_x, y: i_point_y};
            WR_RD:   wr_data = rd_pt;
            WR_PIV:  wr_data = r_piv;
            WR_OPC:  wr_data = r_oc;
            WR_T:    wr_data = r_t;
            default: wr_data = r_t;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_pt[i_cmd.wr_addr] <= wr_data;
        end
        if (i_cmd.piv_load) begin
            r_piv <= rd_pt;
        end
        if (i_cmd.t_load) begin
            r_t <= rd_pt;
        end
        if (i_cmd.issue) begin
            r_oa <= i_cmd.scan ? r_top2 : r_piv;
            r_ob <= i_cmd.scan ? r_top1 : r_t;
            r_oc <= i_cmd.scan ? r_t    : rd_pt;
        end
    end

    // cross product and manhattan distances, two register stages
    always_comb begin
        dbx  = DIFF_W'(r_ob.x) - DIFF_W'(r_oa.x);
        dby  = DIFF_W'(r_ob.y) - DIFF_W'(r_oa.y);
        dcx  = DIFF_W'(r_oc.x) - DIFF_W'(r_oa.x);
        dcy  = DIFF_W'(r_oc.y) - DIFF_W'(r_oa.y);
        abx  = dbx[DIFF_W-1] ? DIFF_W'(-dbx) : DIFF_W'(dbx);
        aby  = dby[DIFF_W-1] ? DIFF_W'(-dby) : DIFF_W'(dby);
        acx  = dcx[DIFF_W-1] ? DIFF_W'(-dcx) : DIFF_W'(dcx);
        acy  = dcy[DIFF_W-1] ? DIFF_W'(-dcy) : DIFF_W'(dcy);
        n_p1 = dbx * dcy;
        n_p2 = dcx * dby;
        n_turn = TURN_W'(r_p1) - TURN_W'(r_p2);
    end

    always_ff @(posedge i_clk) begin
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_mb   <= MAN_W'(abx) + MAN_W'(aby);
        r_mc   <= MAN_W'(acx) + MAN_W'(acy);
        r_neg  <= n_turn[TURN_W-1];
        r_zero <= (n_turn == '0);
        r_near <= (r_mb < r_mc);
    end

    // hull stack with the two top entries mirrored in registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.stk_clr) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_depth <= r_depth - CNT_W'(1);
        end
        if (i_cmd.push) begin
            r_stk[r_depth[IDX_W-1:0]] <= r_t;
            r_top1 <= r_t;
            r_top2 <= r_top1;
        end else if (i_cmd.pop) begin
            r_top1 <= r_top2;
            r_top2 <= stk_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_hx   <= stk_rd.x;
            r_hy   <= stk_rd.y;
            r_hs   <= sat_size(r_depth);
            r_last <= o_sts.emit_last;
        end
    end

    always_comb begin
        o_sts.less      = (rd_pt.y < r_piv.y) || ((rd_pt.y == r_piv.y) && (rd_pt.x < r_piv.x));
        o_sts.precedes  = r_zero ? r_near : r_neg;
        o_sts.nonneg    = !r_neg;
        o_sts.depth_ge2 = (r_depth >= CNT_W'(2));
        o_sts.emit_last = ((CNT_W'(i_cmd.rd_addr) + CNT_W'(1)) == r_depth);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hull_x      = r_hx;
    assign o_hull_y      = r_hy;
    assign o_hull_size   = r_hs;
    assign o_last_vertex = r_last;

`ifndef SYNTHESIS
    a_pop_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_depth >= CNT_W'(2)))
        else $error("hull stack popped below two entries");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_depth < CNT_W'(POINT_COUNT)))
        else $error("hull stack pushed past its depth");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("output valid rose without a load");
`endif

endmodule

@@ rtl/convex_hull_8_points_core.sv @@
// convex_hull_8_points_core: top level of the graham scan convex hull block
// depends on chull_pkg, chull_ctrl and chull_dp
//
// input channel: one point per item (i_point_x, i_point_y, signed q12.4),
// accepted when i_in_valid is high and o_in_stall is low. o_in_stall is low
// only while points of a set are being loaded, one item per cycle.
// after the eighth point the block finds the pivot, swaps it into place,
// insertion-sorts the rest and runs the stack scan. every compare and turn
// test goes through one shared, two-stage cross-product unit.
// output channel: hull vertices in stack order with hull size and a last flag,
// one per cycle while i_out_stall is low; a stall holds the output register
// and emission waits. the last vertex stays in the output register while the
// next set already loads.
// reset (synchronous, active low) empties the point counter, the stack depth
// and the output valid.
module convex_hull_8_points_core import chull_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_coord            i_point_x,
    input  t_coord            i_point_y,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_coord            o_hull_x,
    output t_coord            o_hull_y,
    output logic [SIZE_W-1:0] o_hull_size,
    output logic              o_last_vertex
);

    t_cmd cmd;
    t_sts sts;

    chull_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    chull_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hull_x      (o_hull_x),
        .o_hull_y      (o_hull_y),
        .o_hull_size   (o_hull_size),
        .o_last_vertex (o_last_vertex)
    );

endmodule
